// ----- sv/ldpc_ed_pkg.sv -----
`default_nettype none
package ldpc_ed_pkg;

    localparam int CHECKS     = 9;
    localparam int VARS       = 12;
    localparam int ROW_WEIGHT = 4;
    localparam int COL_WEIGHT = 3;

    localparam int ROW_W  = $clog2(CHECKS);
    localparam int VAR_W  = $clog2(VARS);
    localparam int SEEN_W = $clog2(COL_WEIGHT + 1);
    localparam int ITER_W = 6;
    localparam int STEP_W = 3;

    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(15);

    typedef logic [1:0] sym_t;
    localparam sym_t ERASED = 2'd2;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CLEAR,
        OP_CHECK,
        OP_COMMIT,
        OP_EMIT,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_START,
        COND_ITER_ZERO,
        COND_ROW_MORE,
        COND_ITER_MORE,
        COND_EMIT,
        COND_JUMP
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic start_fire;
        logic iter_zero;
        logic row_more;
        logic iter_more;
        logic out_ready;
        logic emit_more;
    } status_t;

    localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_CLEAR = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_CHECK = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(5);

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            3'd0:    w = '{OP_IDLE,   COND_START,     STEP_IDLE};
            3'd1:    w = '{OP_LOAD,   COND_ITER_ZERO, STEP_EMIT};
            3'd2:    w = '{OP_CLEAR,  COND_NEXT,      STEP_IDLE};
            3'd3:    w = '{OP_CHECK,  COND_ROW_MORE,  STEP_CHECK};
            3'd4:    w = '{OP_COMMIT, COND_ITER_MORE, STEP_CLEAR};
            3'd5:    w = '{OP_EMIT,   COND_EMIT,      STEP_EMIT};
            default: w = '{OP_NOP,    COND_JUMP,      STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [VARS-1:0] trim_row(input logic [VARS-1:0] row);
        logic [VARS-1:0] kept;
        int              count;
        kept  = '0;
        count = 0;
        for (int j = 0; j < VARS; j++) begin
            if (row[j] && count < ROW_WEIGHT) begin
                kept[j] = 1'b1;
                count   = count + 1;
            end
        end
        return kept;
    endfunction

endpackage
`default_nettype wire

// ----- sv/ldpc_erasure_decoder_top.sv -----
// Loads: one item per cycle while idle, matrix rows and symbols apply at once.
// Decode: the start item is followed by a load step and N iterations (each
// one clear step, one step per check row and one commit step; none if N is 0),
// then VARS results, one per cycle while m_ready is high, then a NOP step to idle.
// Reset (synchronous, active low): iteration count 15, received word all erased;
// matrix rows are undefined until written.
`default_nettype none
module ldpc_erasure_decoder_top
    import ldpc_ed_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [ITER_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_kind,
    input  wire logic [3:0]        s_row_number,
    input  wire logic [VARS-1:0]   s_row_bits,
    input  wire logic [3:0]        s_symbol_position,
    input  wire logic [1:0]        s_symbol_value,
    input  wire logic              s_start_decode,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [3:0]             m_decoded_position,
    output logic [1:0]             m_decoded_value,
    output logic                   m_final_symbol
);

    ctrl_t   ctrl;
    status_t status;

    logic [VARS-1:0]   mat_reg      [CHECKS];
    logic [VARS-1:0]   mat_next     [CHECKS];
    sym_t              recv_reg     [VARS];
    sym_t              recv_next    [VARS];
    sym_t              est_reg      [VARS];
    sym_t              est_next     [VARS];
    sym_t              nest_reg     [VARS];
    sym_t              nest_next    [VARS];
    logic [SEEN_W-1:0] seen_reg     [VARS];
    logic [SEEN_W-1:0] seen_next    [VARS];
    logic [ITER_W-1:0] iter_cfg_reg;
    logic [ITER_W-1:0] iter_cfg_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [VAR_W-1:0]  pos_reg;
    logic [VAR_W-1:0]  pos_next;

    logic            in_fire;
    logic [VARS-1:0] row_cur;
    logic            any_erased;
    logic            two_erased;
    logic            parity;

    ldpc_ed_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign s_ready = (ctrl.op == OP_IDLE);
    assign in_fire = s_valid && s_ready;
    assign m_valid = (ctrl.op == OP_EMIT);

    assign m_decoded_position = 4'(pos_reg);
    assign m_decoded_value    = est_reg[pos_reg];
    assign m_final_symbol     = (pos_reg == VAR_W'(VARS - 1));

    assign status.start_fire = in_fire && s_kind && s_start_decode;
    assign status.iter_zero  = (iter_cfg_reg == '0);
    assign status.row_more   = (row_reg != ROW_W'(CHECKS - 1));
    assign status.iter_more  = (iter_reg != ITER_W'(1));
    assign status.out_ready  = m_ready;
    assign status.emit_more  = (pos_reg != VAR_W'(VARS - 1));

    assign row_cur = mat_reg[row_reg];

    always_comb begin
        any_erased = 1'b0;
        two_erased = 1'b0;
        parity     = 1'b0;
        for (int j = 0; j < VARS; j++) begin
            if (row_cur[j]) begin
                two_erased = two_erased || (any_erased && est_reg[j][1]);
                any_erased = any_erased || est_reg[j][1];
                parity     = parity ^ est_reg[j][0];
            end
        end
    end

    always_comb begin
        mat_next      = mat_reg;
        recv_next     = recv_reg;
        est_next      = est_reg;
        nest_next     = nest_reg;
        seen_next     = seen_reg;
        iter_cfg_next = iter_cfg_reg;
        iter_next     = iter_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;

        if (cfg_wr_en) begin
            iter_cfg_next = cfg_wr_data;
        end

        unique case (ctrl.op)
            OP_IDLE: begin
                if (in_fire && !s_kind && s_row_number < 4'(CHECKS)) begin
                    mat_next[ROW_W'(s_row_number)] = trim_row(s_row_bits);
                end
                if (in_fire && s_kind && s_symbol_position < 4'(VARS)) begin
                    recv_next[VAR_W'(s_symbol_position)] =
                        (s_symbol_value > 2'd1) ? ERASED : s_symbol_value;
                end
            end
            OP_LOAD: begin
                est_next  = recv_reg;
                iter_next = iter_cfg_reg;
                pos_next  = '0;
            end
            OP_CLEAR: begin
                nest_next = recv_reg;
                for (int j = 0; j < VARS; j++) begin
                    seen_next[j] = '0;
                end
                row_next = '0;
            end
            OP_CHECK: begin
                for (int j = 0; j < VARS; j++) begin
                    if (row_cur[j] && recv_reg[j][1] && nest_reg[j][1]
                            && seen_reg[j] < SEEN_W'(COL_WEIGHT)) begin
                        seen_next[j] = seen_reg[j] + SEEN_W'(1);
                        if (!(est_reg[j][1] ? two_erased : any_erased)) begin
                            nest_next[j] = {1'b0, parity ^ est_reg[j][0]};
                        end
                    end
                end
                row_next = row_reg + ROW_W'(1);
            end
            OP_COMMIT: begin
                est_next  = nest_reg;
                iter_next = iter_reg - ITER_W'(1);
            end
            OP_EMIT: begin
                if (m_ready) begin
                    pos_next = pos_reg + VAR_W'(1);
                end
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_cfg_reg <= ITER_RESET;
            iter_reg     <= '0;
            row_reg      <= '0;
            pos_reg      <= '0;
            for (int j = 0; j < VARS; j++) begin
                recv_reg[j] <= ERASED;
            end
        end else begin
            iter_cfg_reg <= iter_cfg_next;
            iter_reg     <= iter_next;
            row_reg      <= row_next;
            pos_reg      <= pos_next;
            recv_reg     <= recv_next;
        end
    end

    always_ff @(posedge aclk) begin
        mat_reg  <= mat_next;
        est_reg  <= est_next;
        nest_reg <= nest_next;
        seen_reg <= seen_next;
    end

endmodule
`default_nettype wire

// ----- sv/ldpc_ed_seq.sv -----
`default_nettype none
module ldpc_ed_seq
    import ldpc_ed_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl = ucode(step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        step_next = step_reg + STEP_W'(1);
        unique case (ctrl.cond)
            COND_NEXT:      step_next = step_reg + STEP_W'(1);
            COND_START:     step_next = status.start_fire ? step_reg + STEP_W'(1) : step_reg;
            COND_ITER_ZERO: if (status.iter_zero) step_next = ctrl.target;
            COND_ROW_MORE:  if (status.row_more) step_next = ctrl.target;
            COND_ITER_MORE: if (status.iter_more) step_next = ctrl.target;
            COND_EMIT: begin
                if (!status.out_ready) begin
                    step_next = step_reg;
                end else if (status.emit_more) begin
                    step_next = ctrl.target;
                end
            end
            COND_JUMP:      step_next = ctrl.target;
            default:        step_next = STEP_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import ldpc_ed_pkg::*;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;
    localparam sym_t SYM_INVALID = 2'd3;

    typedef sym_t [VARS-1:0] sym_word_t;

    typedef struct packed {
        logic            kind;
        logic [3:0]      row_number;
        logic [VARS-1:0] row_bits;
        logic [3:0]      symbol_position;
        logic [1:0]      symbol_value;
        logic            start_decode;
    } load_item_t;

    typedef struct packed {
        load_item_t item;
        logic       typed;
        sym_word_t  word;
    } vector_t;

    typedef struct packed {
        logic [3:0] position;
        sym_t       value;
        logic       last;
    } out_sym_t;

    localparam int N_DIRECTED = 22;
    localparam vector_t DIRECTED [N_DIRECTED] = '{
        '{'{KIND_ROW,    4'd0,  12'hfff, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd1,  12'h0f0, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd2,  12'hf00, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd3,  12'h111, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd4,  12'h222, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd5,  12'h444, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd6,  12'h888, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd7,  12'h801, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd8,  12'h003, 4'd0,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_ROW,    4'd15, 12'hfff, 4'd15, 2'd3,        1'b1}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd15, SYM_INVALID, 1'b1}, 1'b1, {VARS{ERASED}}},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd0,  2'd1,        1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd1,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd2,  SYM_INVALID, 1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd4,  2'd1,        1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd5,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd6,  2'd1,        1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd8,  2'd0,        1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd9,  2'd1,        1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd10, ERASED,      1'b0}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd0,  12'h000, 4'd11, 2'd1,        1'b1}, 1'b0, '0},
        '{'{KIND_SYMBOL, 4'd9,  12'hfff, 4'd13, 2'd0,        1'b1}, 1'b0, '0}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [ITER_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_kind = 1'b0;
    logic [3:0]        s_row_number = '0;
    logic [VARS-1:0]   s_row_bits = '0;
    logic [3:0]        s_symbol_position = '0;
    logic [1:0]        s_symbol_value = '0;
    logic              s_start_decode = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [3:0]        m_decoded_position;
    logic [1:0]        m_decoded_value;
    logic              m_final_symbol;

    logic [VARS-1:0]   h_rows [CHECKS];
    sym_t              rx_sym [VARS];
    sym_t              est_sym [VARS];
    logic [ITER_W-1:0] iter_setting = ITER_RESET;
    out_sym_t          pending_symbols [$];
    int                fail_count = 0;
    bit                steady = 1'b0;

    ldpc_erasure_decoder_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_row_number       (s_row_number),
        .s_row_bits         (s_row_bits),
        .s_symbol_position  (s_symbol_position),
        .s_symbol_value     (s_symbol_value),
        .s_start_decode     (s_start_decode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_decoded_position (m_decoded_position),
        .m_decoded_value    (m_decoded_value),
        .m_final_symbol     (m_final_symbol)
    );

    always #5 aclk = ~aclk;

    function automatic logic [VARS-1:0] first_ones(input logic [VARS-1:0] row);
        logic [VARS-1:0] kept;
        int              n;
        kept = '0;
        n    = 0;
        for (int j = 0; j < VARS && n < ROW_WEIGHT; j++) begin
            if (row[j]) begin
                kept[j] = 1'b1;
                n++;
            end
        end
        return kept;
    endfunction

    function automatic sym_t parity_msg(input logic [VARS-1:0] row, input int skip);
        sym_t acc;
        acc = 2'd0;
        for (int j = 0; j < VARS; j++) begin
            if (j != skip && row[j]) begin
                if (est_sym[j] == ERASED) return ERASED;
                acc = acc ^ est_sym[j];
            end
        end
        return acc;
    endfunction

    function automatic sym_word_t decode_word();
        logic [VARS-1:0] rows [CHECKS];
        sym_t            nxt [VARS];
        sym_word_t       w;
        int              seen;
        for (int i = 0; i < CHECKS; i++) rows[i] = first_ones(h_rows[i]);
        for (int j = 0; j < VARS; j++) est_sym[j] = rx_sym[j];
        for (int it = 0; it < int'(iter_setting); it++) begin
            for (int j = 0; j < VARS; j++) begin
                nxt[j] = rx_sym[j];
                seen   = 0;
                for (int i = 0; i < CHECKS && seen < COL_WEIGHT && nxt[j] == ERASED; i++) begin
                    if (rows[i][j]) begin
                        seen++;
                        nxt[j] = parity_msg(rows[i], j);
                    end
                end
            end
            for (int j = 0; j < VARS; j++) est_sym[j] = nxt[j];
        end
        for (int j = 0; j < VARS; j++) w[j] = est_sym[j];
        return w;
    endfunction

    function automatic load_item_t rand_row();
        load_item_t it;
        it      = $bits(load_item_t)'($urandom);
        it.kind = KIND_ROW;
        if ($urandom_range(99) < 10) begin
            it.row_number = 4'($urandom_range(15, CHECKS));
        end else begin
            it.row_number = 4'($urandom_range(CHECKS - 1));
        end
        if ($urandom_range(1) == 1) begin
            it.row_bits = (VARS'(1) << $urandom_range(VARS - 1))
                        | (VARS'(1) << $urandom_range(VARS - 1))
                        | (VARS'(1) << $urandom_range(VARS - 1));
        end
        return it;
    endfunction

    function automatic load_item_t rand_symbol(input bit last);
        load_item_t it;
        int         r;
        it      = $bits(load_item_t)'($urandom);
        it.kind = KIND_SYMBOL;
        if ($urandom_range(99) < 8) begin
            it.symbol_position = 4'($urandom_range(15, VARS));
        end else begin
            it.symbol_position = 4'($urandom_range(VARS - 1));
        end
        r = $urandom_range(99);
        if (r < 30) begin
            it.symbol_value = ERASED;
        end else if (r < 36) begin
            it.symbol_value = SYM_INVALID;
        end else begin
            it.symbol_value = 2'($urandom_range(1));
        end
        it.start_decode = last;
        return it;
    endfunction

    task automatic send_item(input load_item_t it, input logic typed, input sym_word_t typed_w);
        sym_word_t w;
        while (!steady && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_kind            <= it.kind;
        s_row_number      <= it.row_number;
        s_row_bits        <= it.row_bits;
        s_symbol_position <= it.symbol_position;
        s_symbol_value    <= it.symbol_value;
        s_start_decode    <= it.start_decode;
        do @(posedge aclk); while (!s_ready);
        if (it.kind == KIND_ROW) begin
            if (it.row_number < CHECKS) h_rows[it.row_number] = it.row_bits;
        end else begin
            if (it.symbol_position < VARS) begin
                rx_sym[it.symbol_position] = it.symbol_value[1] ? ERASED : it.symbol_value;
            end
            if (it.start_decode) begin
                w = decode_word();
                if (typed) w = typed_w;
                for (int j = 0; j < VARS; j++) begin
                    pending_symbols.push_back('{4'(j), w[j], j == VARS - 1});
                end
            end
        end
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input int quota);
        int sent;
        int n_sym;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 8) hold_until_drained();
            if ($urandom_range(99) < 12) begin
                send_item($bits(load_item_t)'($urandom), 1'b0, '0);
                sent++;
            end else begin
                if ($urandom_range(99) < 35) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(rand_row(), 1'b0, '0);
                        sent++;
                    end
                end
                n_sym = $urandom_range(1, VARS);
                for (int k = 0; k < n_sym; k++) begin
                    send_item(rand_symbol(k == n_sym - 1), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        out_sym_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_symbols.size() == 0) begin
                $error("unexpected result, decoded_position %0d", m_decoded_position);
                fail_count++;
            end else begin
                want = pending_symbols.pop_front();
                if (m_decoded_position !== want.position) begin
                    $error("decoded_position expected %0d got %0d",
                           want.position, m_decoded_position);
                    fail_count++;
                end
                if (m_decoded_value !== want.value) begin
                    $error("decoded_value expected %0d got %0d", want.value, m_decoded_value);
                    fail_count++;
                end
                if (m_final_symbol !== want.last) begin
                    $error("final_symbol expected %0d got %0d", want.last, m_final_symbol);
                    fail_count++;
                end
            end
        end
        m_ready <= steady || ($urandom_range(99) >= 22);
    end

    initial begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [ITER_W-1:0] setting;
        int                quota;
        for (int j = 0; j < VARS; j++) rx_sym[j] = ERASED;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].word);
        end
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin setting = 6'd1;  quota = 60;  end
                1: begin setting = 6'd63; quota = 40;  end
                2: begin setting = 6'd0;  quota = 40;  end
                3: begin setting = ITER_W'($urandom_range(2, 12)); quota = 100; end
                default: begin setting = 6'd3; quota = 80; end
            endcase
            hold_until_drained();
            cfg_wr_en    <= 1'b1;
            cfg_wr_data  <= setting;
            @(posedge aclk);
            cfg_wr_en    <= 1'b0;
            iter_setting = setting;
            steady       = (p == 3);
            run_phase(quota);
        end
        steady = 1'b0;
        s_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ldpc_ed_pkg.sv
sv/ldpc_ed_seq.sv
sv/ldpc_erasure_decoder_top.sv
bench/tb.sv
